@@ rtl/hrf_pkg.sv @@
package hrf_pkg;

	// counter width default and fixed config register width
	localparam int COUNT_WIDTH_DEF = 21;
	localparam int CFG_WIDTH       = 21;
	localparam int CFG_INDEX_WIDTH = 1;

	// header name and blank line lengths
	localparam int NAME_LEN = 15;
	localparam int TERM_LEN = 4;

	localparam logic [CFG_WIDTH-1:0] MAX_REQUEST_RESET = CFG_WIDTH'(131072);
	localparam logic [CFG_WIDTH-1:0] MAX_BODY_RESET    = CFG_WIDTH'(65536);

	// config register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_MAX_REQUEST = 1'b0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_MAX_BODY    = 1'b1;

	// input operations
	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_CLOSE = 1'b1;

	// result status codes
	localparam logic [2:0] STAT_BUSY       = 3'd0;
	localparam logic [2:0] STAT_COMPLETE   = 3'd1;
	localparam logic [2:0] STAT_CLOSED     = 3'd2;
	localparam logic [2:0] STAT_BODY_LARGE = 3'd3;
	localparam logic [2:0] STAT_REQ_LARGE  = 3'd4;

	// number parse phases
	localparam logic [1:0] PH_NAME   = 2'd0;
	localparam logic [1:0] PH_LEAD   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_PLUS  = 8'h2b;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;

	typedef struct packed {
		logic [2:0] term_match;
		logic [3:0] name_match;
		logic [1:0] phase;
		logic       negative;
	} hrf_scan_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) ? (c + 8'd32) : c;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// "content-length:" one character per position
	function automatic logic [7:0] name_char(input logic [3:0] i);
		logic [7:0] ch;
		unique case (i)
			4'd0:    ch = 8'h63; // c
			4'd1:    ch = 8'h6f; // o
			4'd2:    ch = 8'h6e; // n
			4'd3:    ch = 8'h74; // t
			4'd4:    ch = 8'h65; // e
			4'd5:    ch = 8'h6e; // n
			4'd6:    ch = 8'h74; // t
			4'd7:    ch = 8'h2d; // -
			4'd8:    ch = 8'h6c; // l
			4'd9:    ch = 8'h65; // e
			4'd10:   ch = 8'h6e; // n
			4'd11:   ch = 8'h67; // g
			4'd12:   ch = 8'h74; // t
			4'd13:   ch = 8'h68; // h
			4'd14:   ch = 8'h3a; // :
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

@@ rtl/hrf_scan.sv @@
module hrf_scan import hrf_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic [7:0]             data_byte,
	input  hrf_scan_t              scan_cur,
	input  logic [COUNT_WIDTH-1:0] length_cur,
	output hrf_scan_t              scan_next,
	output logic [COUNT_WIDTH-1:0] length_next
);

	logic [7:0]             lc;
	logic                   digit;
	logic [3:0]             name_inc;
	logic [COUNT_WIDTH+3:0] times_ten;
	logic [COUNT_WIDTH-1:0] digit_val;

	assign lc        = to_lower(data_byte);
	assign digit     = is_digit(data_byte);
	assign digit_val = COUNT_WIDTH'(data_byte - CHAR_ZERO);
	assign times_ten = ({4'b0, length_cur} << 3) + ({4'b0, length_cur} << 1)
		+ (COUNT_WIDTH+4)'(data_byte[3:0]);

	always_comb begin
		scan_next   = scan_cur;
		length_next = length_cur;
		name_inc    = '0;

		unique case (scan_cur.phase)
			PH_NAME: begin
				if (scan_cur.name_match < 4'(NAME_LEN) && lc == name_char(scan_cur.name_match))
					name_inc = scan_cur.name_match + 4'd1;
				else
					name_inc = (lc == name_char(4'd0)) ? 4'd1 : 4'd0;
				if (name_inc >= 4'(NAME_LEN)) begin
					scan_next.name_match = '0;
					scan_next.phase      = PH_LEAD;
				end else begin
					scan_next.name_match = name_inc;
				end
			end
			PH_LEAD: begin
				priority if (is_blank(data_byte)) begin
					scan_next.phase = PH_LEAD;
				end else if (data_byte == CHAR_PLUS || data_byte == CHAR_MINUS) begin
					scan_next.negative = (data_byte == CHAR_MINUS);
					scan_next.phase    = PH_DIGITS;
				end else if (digit) begin
					length_next     = digit_val;
					scan_next.phase = PH_DIGITS;
				end else begin
					scan_next.phase = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (digit) begin
					// saturate at all ones
					if (|times_ten[COUNT_WIDTH+3:COUNT_WIDTH])
						length_next = '1;
					else
						length_next = times_ten[COUNT_WIDTH-1:0];
				end else begin
					scan_next.phase = PH_DONE;
				end
			end
			PH_DONE: begin
				scan_next.phase = PH_DONE;
			end
			default: begin
				scan_next.phase = scan_cur.phase;
			end
		endcase

		// blank line search
		priority if (data_byte == CHAR_CR)
			scan_next.term_match = (scan_cur.term_match == 3'd2) ? 3'd3 : 3'd1;
		else if (data_byte == CHAR_LF
			&& (scan_cur.term_match == 3'd1 || scan_cur.term_match == 3'd3))
			scan_next.term_match = scan_cur.term_match + 3'd1;
		else
			scan_next.term_match = '0;
	end

endmodule

@@ rtl/hrf_core.sv @@
module hrf_core import hrf_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic                   operation,
	input  logic [7:0]             data_byte,
	input  logic [CFG_WIDTH-1:0]   max_request_bytes,
	input  logic [CFG_WIDTH-1:0]   max_body_bytes,
	output logic [2:0]             status,
	output logic [COUNT_WIDTH-1:0] header_length,
	output logic [COUNT_WIDTH-1:0] body_length,
	output logic [COUNT_WIDTH-1:0] byte_count
);

	localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

	logic                   in_body_q, in_body_d;
	hrf_scan_t              scan_q, scan_d, scan_nx;
	logic [COUNT_WIDTH-1:0] length_q, length_d, length_nx;
	logic [COUNT_WIDTH-1:0] bytes_q, bytes_d, bytes_inc;
	logic [COUNT_WIDTH-1:0] header_q, header_d;
	logic [COUNT_WIDTH:0]   body_end;
	logic                   over_size;
	logic                   body_done;
	logic                   len_bad;

	hrf_scan #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_scan (
		.data_byte  (data_byte),
		.scan_cur   (scan_q),
		.length_cur (length_q),
		.scan_next  (scan_nx),
		.length_next(length_nx)
	);

	assign bytes_inc = (&bytes_q) ? bytes_q : bytes_q + 1'b1;
	assign over_size = CMP_WIDTH'(bytes_inc) > CMP_WIDTH'(max_request_bytes);
	assign body_end  = {1'b0, header_q} + {1'b0, length_q};
	assign body_done = {1'b0, bytes_inc} >= body_end;
	assign len_bad   = (scan_nx.negative && (|length_nx))
		|| (CMP_WIDTH'(length_nx) > CMP_WIDTH'(max_body_bytes));

	always_comb begin
		status    = STAT_BUSY;
		in_body_d = in_body_q;
		scan_d    = scan_q;
		length_d  = length_q;
		bytes_d   = bytes_q;
		header_d  = header_q;
		priority if (operation == OP_CLOSE) begin
			status = STAT_CLOSED;
		end else begin
			bytes_d = bytes_inc;
			priority if (over_size) begin
				status = STAT_REQ_LARGE;
			end else if (!in_body_q) begin
				scan_d   = scan_nx;
				length_d = length_nx;
				if (scan_nx.term_match == 3'(TERM_LEN)) begin
					scan_d.term_match = '0;
					header_d          = bytes_inc;
					priority if (len_bad)
						status = STAT_BODY_LARGE;
					else if (length_nx == '0)
						status = STAT_COMPLETE;
					else
						in_body_d = 1'b1;
				end
			end else if (body_done) begin
				status = STAT_COMPLETE;
			end
		end
	end

	assign header_length = header_d;
	assign byte_count    = bytes_d;

	always_comb begin
		priority if (!in_body_d && header_d == '0)
			body_length = '0;
		else if (scan_d.negative && (|length_d))
			body_length = '1;
		else
			body_length = length_d;
	end

	// any final status restarts the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_body_q <= 1'b0;
			scan_q    <= '0;
			length_q  <= '0;
			bytes_q   <= '0;
			header_q  <= '0;
		end else if (advance) begin
			if (status != STAT_BUSY) begin
				in_body_q <= 1'b0;
				scan_q    <= '0;
				length_q  <= '0;
				bytes_q   <= '0;
				header_q  <= '0;
			end else begin
				in_body_q <= in_body_d;
				scan_q    <= scan_d;
				length_q  <= length_d;
				bytes_q   <= bytes_d;
				header_q  <= header_d;
			end
		end
	end

endmodule

@@ rtl/http_request_framer_top.sv @@
// path: a byte transfer loads the input register, and its result then loads the
//   result register that drives m_axis; an output stall holds the byte in the
//   input register
// throughput: one byte per cycle while m_axis is not stalled; the request state updates once per byte
// reset: arst_n clears all request state and loads the config register defaults
//   (max_request_bytes 131072, max_body_bytes 65536); no clearing pass
module http_request_framer_top import hrf_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request byte stream
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
	input  logic                         s_axis_tuser,  // [0] operation
	// one result per byte or close
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// status, header_length, body_length, byte_count from bit 0 up, zero pad
	output logic [((3+3*COUNT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// config writes
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [CFG_WIDTH-1:0]         cfg_data
);

	localparam int FIELD_BITS = 3 + 3 * COUNT_WIDTH;
	localparam int DATA_BITS  = ((FIELD_BITS + 7) / 8) * 8;

	// config registers
	logic [CFG_WIDTH-1:0] max_request_q;
	logic [CFG_WIDTH-1:0] max_body_q;

	// input register stage
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;

	// result register
	logic                   out_valid_q;
	logic [2:0]             status_q;
	logic [COUNT_WIDTH-1:0] header_q;
	logic [COUNT_WIDTH-1:0] content_q;
	logic [COUNT_WIDTH-1:0] count_q;

	// combinational result of the byte in the input register
	logic [2:0]             status_c;
	logic [COUNT_WIDTH-1:0] header_c;
	logic [COUNT_WIDTH-1:0] content_c;
	logic [COUNT_WIDTH-1:0] count_c;

	logic advance;

	// the byte in stage 1 moves on when the result slot is free or draining
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// config writes are always taken; the user must send them only while the framer is idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_request_q <= MAX_REQUEST_RESET;
			max_body_q    <= MAX_BODY_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IDX_MAX_REQUEST: max_request_q <= cfg_data;
				CFG_IDX_MAX_BODY:    max_body_q    <= cfg_data;
				default:             max_body_q    <= max_body_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	// per-byte framing logic and request state
	hrf_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (advance),
		.operation        (op_s1),
		.data_byte        (byte_s1),
		.max_request_bytes(max_request_q),
		.max_body_bytes   (max_body_q),
		.status           (status_c),
		.header_length    (header_c),
		.body_length      (content_c),
		.byte_count       (count_c)
	);

	// result register, holds while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q  <= status_c;
			header_q  <= header_c;
			content_q <= content_c;
			count_q   <= count_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = DATA_BITS'({count_q, content_q, header_q, status_q});

endmodule

@@ tb/tb_http_request_framer_top.sv @@
module tb_http_request_framer_top;
	import hrf_pkg::*;

	localparam int CW          = COUNT_WIDTH_DEF;
	localparam int OUT_W       = ((3 + 3 * CW + 7) / 8) * 8;
	localparam int MAX_WAIT    = 17;
	localparam int PHASE_BYTES = 165;
	localparam int NUM_PHASES  = 10;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PRINT_CAP   = 100;

	localparam logic [CW-1:0] COUNT_TOP  = '1;
	localparam logic [7:0]    CHAR_TAB   = 8'h09;
	localparam logic [7:0]    CHAR_SPACE = 8'h20;
	localparam logic [7:0]    CHAR_NINE  = 8'h39;
	localparam logic [CFG_WIDTH-1:0] LIMIT_TOP = CFG_WIDTH'(1048576);

	// header name, one character per index
	localparam logic [0:NAME_LEN-1][7:0] FIELD_NAME = "content-length:";

	// one input transfer: close flag and byte
	typedef struct packed {
		logic       op;
		logic [7:0] data;
	} framer_item_t;

	// result fields, status in the low bits as on m_axis_tdata
	typedef struct packed {
		logic [CW-1:0] byte_count;
		logic [CW-1:0] body_length;
		logic [CW-1:0] header_length;
		logic [2:0]    status;
	} frame_result_t;

	localparam int RESULT_BITS = $bits(frame_result_t);

	logic                       clk           = 1'b0;
	logic                       arst_n        = 1'b0;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [7:0]                 s_axis_tdata  = '0;
	logic                       s_axis_tuser  = OP_DATA;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [OUT_W-1:0]           m_axis_tdata;
	logic                       cfg_valid     = 1'b0;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index     = CFG_IDX_MAX_REQUEST;
	logic [CFG_WIDTH-1:0]       cfg_data      = '0;

	http_request_framer_top #(
		.COUNT_WIDTH(CW)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// framer prediction state, limits track accepted config writes
	logic [CFG_WIDTH-1:0] lim_request   = MAX_REQUEST_RESET;
	logic [CFG_WIDTH-1:0] lim_body      = MAX_BODY_RESET;
	logic                 body_started  = 1'b0;
	logic [2:0]           crlf_count    = '0;
	logic [3:0]           name_pos      = '0;
	logic [1:0]           parse_phase   = PH_NAME;
	logic                 parse_neg     = 1'b0;
	logic [CW-1:0]        parsed_len    = '0;
	logic [CW-1:0]        request_bytes = '0;
	logic [CW-1:0]        header_bytes  = '0;

	framer_item_t  pending_items[$];
	frame_result_t expected_frames[$];

	bit item_held    = 1'b0;
	bit in_idle_on   = 1'b1;
	bit out_idle_on  = 1'b1;
	int in_wait      = 0;
	int out_wait     = 0;
	int phase_items  = 0;
	int error_count  = 0;
	int result_index = 0;
	int cycle_count  = 0;

	// advances the framer by one transfer and returns the result it shows
	function automatic frame_result_t advance_framer(input logic op, input logic [7:0] ch);
		frame_result_t res;
		logic [7:0]    low_ch;
		logic [CW+3:0] grown;
		logic          is_num;
		res = '0;
		res.status = STAT_BUSY;
		is_num = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
		if (op == OP_CLOSE) begin
			res.status = STAT_CLOSED;
		end else begin
			if (request_bytes != COUNT_TOP)
				request_bytes = request_bytes + 1'b1;
			// size limit wins over everything else for this byte
			if (request_bytes > lim_request) begin
				res.status = STAT_REQ_LARGE;
			end else if (!body_started) begin
				case (parse_phase)
					PH_NAME: begin
						low_ch = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
						if (name_pos < NAME_LEN && low_ch == FIELD_NAME[name_pos])
							name_pos = name_pos + 1'b1;
						else
							name_pos = (low_ch == FIELD_NAME[0]) ? 4'd1 : 4'd0;
						if (name_pos >= NAME_LEN) begin
							name_pos = '0;
							parse_phase = PH_LEAD;
						end
					end
					PH_LEAD: begin
						if (ch == CHAR_SPACE || (ch >= CHAR_TAB && ch <= CHAR_CR)) begin
							// whitespace before the number
						end else if (ch == CHAR_PLUS || ch == CHAR_MINUS) begin
							parse_neg = (ch == CHAR_MINUS);
							parse_phase = PH_DIGITS;
						end else if (is_num) begin
							parsed_len = CW'(ch - CHAR_ZERO);
							parse_phase = PH_DIGITS;
						end else begin
							parse_phase = PH_DONE;
						end
					end
					PH_DIGITS: begin
						if (is_num) begin
							grown = {4'b0, parsed_len} * (CW+4)'(10)
								+ (CW+4)'(ch - CHAR_ZERO);
							parsed_len = (grown > COUNT_TOP) ? COUNT_TOP : grown[CW-1:0];
						end else begin
							parse_phase = PH_DONE;
						end
					end
					default: begin
					end
				endcase
				// blank line search
				if (ch == CHAR_CR)
					crlf_count = (crlf_count == 3'd2) ? 3'd3 : 3'd1;
				else if (ch == CHAR_LF && (crlf_count == 3'd1 || crlf_count == 3'd3))
					crlf_count = crlf_count + 1'b1;
				else
					crlf_count = '0;
				if (crlf_count >= TERM_LEN) begin
					crlf_count = '0;
					header_bytes = request_bytes;
					if ((parse_neg && parsed_len != '0) || parsed_len > lim_body)
						res.status = STAT_BODY_LARGE;
					else if (parsed_len == '0)
						res.status = STAT_COMPLETE;
					else
						body_started = 1'b1;
				end
			end else if ({1'b0, request_bytes} >= {1'b0, header_bytes} + {1'b0, parsed_len}) begin
				res.status = STAT_COMPLETE;
			end
		end
		res.header_length = header_bytes;
		if (!body_started && header_bytes == '0)
			res.body_length = '0;
		else if (parse_neg && parsed_len != '0)
			res.body_length = COUNT_TOP;
		else
			res.body_length = parsed_len;
		res.byte_count = request_bytes;
		// any final status starts a fresh request
		if (res.status != STAT_BUSY) begin
			body_started  = 1'b0;
			crlf_count    = '0;
			name_pos      = '0;
			parse_phase   = PH_NAME;
			parse_neg     = 1'b0;
			parsed_len    = '0;
			request_bytes = '0;
			header_bytes  = '0;
		end
		return res;
	endfunction

	function automatic int draw_wait(input bit enabled);
		return enabled ? $urandom_range(0, MAX_WAIT) : 0;
	endfunction

	task automatic report_error(input string msg);
		if (error_count < PRINT_CAP)
			$display("[%0d] ERROR: %s", cycle_count, msg);
		error_count++;
	endtask

	task automatic check_field(input string field, input logic [CW-1:0] got,
			input logic [CW-1:0] want);
		if (got !== want)
			report_error($sformatf("result %0d: %s is %0d, expected %0d",
				result_index, field, got, want));
	endtask

	task automatic check_frame(input frame_result_t got);
		frame_result_t want;
		if (expected_frames.size() == 0) begin
			report_error($sformatf("result %0d arrived with none pending, status %0d",
				result_index, got.status));
		end else begin
			want = expected_frames.pop_front();
			check_field("status", CW'(got.status), CW'(want.status));
			check_field("header_length", got.header_length, want.header_length);
			check_field("body_length", got.body_length, want.body_length);
			check_field("byte_count", got.byte_count, want.byte_count);
		end
		result_index++;
	endtask

	// byte stream driver: one transfer per item, random hold-off between items
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_frames.push_back(advance_framer(s_axis_tuser, s_axis_tdata));
				item_held = 1'b0;
				in_wait = draw_wait(in_idle_on);
			end
			if (!item_held) begin
				if (in_wait != 0) begin
					in_wait--;
				end else if (pending_items.size() != 0) begin
					s_axis_tuser <= pending_items[0].op;
					s_axis_tdata <= pending_items[0].data;
					void'(pending_items.pop_front());
					item_held = 1'b1;
				end
			end
			s_axis_tvalid <= item_held;
		end
	end

	// result monitor: checks every transfer, may stall ready for a random wait after each one
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_frame(m_axis_tdata[RESULT_BITS-1:0]);
				out_wait = draw_wait(out_idle_on);
			end else if (out_wait != 0) begin
				out_wait--;
			end
			m_axis_tready <= (out_wait == 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		pending_items.push_back({OP_DATA, b});
		phase_items++;
	endtask

	// data byte rides along with a close and must be ignored
	task automatic push_close();
		pending_items.push_back({OP_CLOSE, 8'($urandom_range(0, 255))});
		phase_items++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	// short header-ish line, sometimes with arbitrary bytes in it
	task automatic push_line();
		int n;
		n = $urandom_range(0, 6);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0)
				push_byte(8'($urandom_range(0, 255)));
			else
				push_byte(8'($urandom_range(8'h20, 8'h7e)));
		end
		push_byte(CHAR_CR);
		push_byte(CHAR_LF);
	endtask

	// header name with random letter case
	task automatic push_name();
		logic [7:0] c;
		for (int i = 0; i < NAME_LEN; i++) begin
			c = FIELD_NAME[i];
			if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
				c = c - 8'd32;
			push_byte(c);
		end
	endtask

	// mostly small lengths, some near the body limit, a few huge
	function automatic int pick_length();
		int n;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: n = $urandom_range(0, 8);
			4, 5, 6:    n = $urandom_range(9, 64);
			7, 8:       n = int'(lim_body) - 1 + int'($urandom_range(0, 2));
			default:    n = $urandom_range(65, 2200000);
		endcase
		return (n < 0) ? 0 : n;
	endfunction

	// one request: request line, optional length header, blank line, body; or noise and a close
	task automatic queue_request();
		int    kind;
		int    n;
		int    cut;
		bit    body_ok;
		string digits;
		kind = $urandom_range(0, 11);
		push_line();
		// plain noise, then the peer drops
		if (kind == 11) begin
			repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
			push_close();
			return;
		end
		if ($urandom_range(0, 1) == 1)
			push_line();
		n = pick_length();
		if (kind != 0) begin
			// partial name first, the matcher has to restart
			if ($urandom_range(0, 3) == 0)
				push_text("conten");
			push_name();
			repeat ($urandom_range(0, 3)) begin
				cut = $urandom_range(0, 7);
				push_byte(cut < 3 ? CHAR_SPACE : CHAR_TAB + 8'(cut - 3));
			end
			if (kind == 5)
				push_byte(CHAR_MINUS);
			else if ($urandom_range(0, 7) == 0)
				push_byte(CHAR_PLUS);
			case (kind)
				6: digits = ($urandom_range(0, 1) == 1) ? "999999999999"
					: $sformatf("%0d", 2097150 + $urandom_range(0, 3));
				7: digits = ($urandom_range(0, 1) == 1) ? "" : "abc";
				default: digits = $sformatf("%0d", n);
			endcase
			if ($urandom_range(0, 4) == 0)
				digits = {"00", digits};
			push_text(digits);
			if ($urandom_range(0, 3) == 0)
				push_byte(CHAR_SPACE);
			push_text("\r\n");
			// a later name never overrides the first
			if (kind == 8) begin
				push_name();
				push_text($sformatf(" %0d\r\n", $urandom_range(0, 99)));
			end
		end else begin
			n = 0;
		end
		// dropped in the middle of the headers
		if ($urandom_range(0, 11) == 0) begin
			push_close();
			return;
		end
		if ($urandom_range(0, 5) == 0)
			push_line();
		push_text("\r\n");
		if (kind == 7)
			n = 0;
		body_ok = (kind != 5) && (kind != 6) && (n <= 64) && (n <= int'(lim_body));
		if (body_ok && n > 0) begin
			cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : n;
			repeat (cut) push_byte(8'($urandom_range(0, 255)));
			if (cut < n)
				push_close();
		end else if ($urandom_range(0, 3) == 0) begin
			push_close();
		end
	endtask

	// config goes in over its own channel, model limits follow the accepted write
	task automatic set_limit(input logic [CFG_INDEX_WIDTH-1:0] idx,
			input logic [CFG_WIDTH-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_IDX_MAX_REQUEST)
			lim_request = value;
		else
			lim_body = value;
	endtask

	// block is idle once nothing is queued, held or outstanding
	task automatic wait_idle();
		while (pending_items.size() != 0 || item_held || expected_frames.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [CFG_WIDTH-1:0] req_lim;
		logic [CFG_WIDTH-1:0] body_lim;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset limits: close with nothing received, extreme bytes,
		// bare blank line, stray CR before the blank line, partial terminator
		push_close();
		push_byte(8'h00);
		push_byte(8'hff);
		push_close();
		push_text("\r\n\r\n");
		push_text("\r\r\n\r\n");
		push_text("\r\n\r");
		push_close();
		wait_idle();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					req_lim  = LIMIT_TOP;
					body_lim = LIMIT_TOP;
				end
				1: begin
					req_lim  = CFG_WIDTH'(1);
					body_lim = '0;
				end
				2: begin
					req_lim  = CFG_WIDTH'(48);
					body_lim = CFG_WIDTH'(12);
				end
				3: begin
					req_lim  = MAX_REQUEST_RESET;
					body_lim = '0;
				end
				4: begin
					req_lim  = CFG_WIDTH'(24);
					body_lim = LIMIT_TOP;
				end
				default: begin
					req_lim  = ($urandom_range(0, 2) == 0) ? LIMIT_TOP
						: CFG_WIDTH'($urandom_range(16, 400));
					body_lim = CFG_WIDTH'($urandom_range(0, 70));
				end
			endcase
			if ($urandom_range(0, 1) == 1) begin
				set_limit(CFG_IDX_MAX_REQUEST, req_lim);
				set_limit(CFG_IDX_MAX_BODY, body_lim);
			end else begin
				set_limit(CFG_IDX_MAX_BODY, body_lim);
				set_limit(CFG_IDX_MAX_REQUEST, req_lim);
			end
			// first phase runs at full rate on both sides
			in_idle_on  = (ph == 2) || (ph != 0 && $urandom_range(0, 3) != 0);
			out_idle_on = (ph == 2) || (ph != 0 && $urandom_range(0, 3) != 0);
			phase_items = 0;
			while (phase_items < PHASE_BYTES)
				queue_request();
			wait_idle();
		end

		// let any stray result surface
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
